### rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg: shared types for the descending record sorter
// Record, beat and cell control types used by the cells and the top level.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int COORD_BITS = 10;
    localparam int WORD_BITS  = 32;

    typedef struct packed {
        logic signed [WORD_BITS-1:0]  key;
        logic        [COORD_BITS-1:0] x;
        logic        [COORD_BITS-1:0] y;
        logic        [COORD_BITS-1:0] z;
        logic        [WORD_BITS-1:0]  dest_value;
        logic        [WORD_BITS-1:0]  dest_x;
        logic        [WORD_BITS-1:0]  dest_y;
        logic        [WORD_BITS-1:0]  dest_z;
    } t_rec;

    typedef struct packed {
        logic signed [WORD_BITS-1:0]  key_value;
        logic        [COORD_BITS-1:0] x_coord;
        logic        [COORD_BITS-1:0] y_coord;
        logic        [COORD_BITS-1:0] z_coord;
        logic        [WORD_BITS-1:0]  dest_value;
        logic        [WORD_BITS-1:0]  dest_x;
        logic        [WORD_BITS-1:0]  dest_y;
        logic        [WORD_BITS-1:0]  dest_z;
        logic                         last_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [WORD_BITS-1:0]  sorted_key;
        logic        [COORD_BITS-1:0] sorted_x;
        logic        [COORD_BITS-1:0] sorted_y;
        logic        [COORD_BITS-1:0] sorted_z;
        logic        [WORD_BITS-1:0]  sorted_dest_value;
        logic        [WORD_BITS-1:0]  sorted_dest_x;
        logic        [WORD_BITS-1:0]  sorted_dest_y;
        logic        [WORD_BITS-1:0]  sorted_dest_z;
        logic                         last_out;
        logic                         overflowed;
    } t_out_beat;

    typedef struct packed {
        logic ins;   // insert the new record into the chain
        logic shl;   // shift the chain one place toward the output
    } t_cell_ctl;

endpackage

### rtl/rsd_cell.sv
// ----------------------------------------------------------------------------
// rsd_cell: one slot of the insertion chain
// Holds one record; on insert keeps, takes the new record or takes the left
// neighbor's; on drain takes the right neighbor's record.
// ----------------------------------------------------------------------------
module rsd_cell
    import rsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_rec      i_new,
    input  t_rec      i_prev_rec,
    input  logic      i_prev_vld,
    input  logic      i_prev_keep,
    input  t_rec      i_next_rec,
    input  logic      i_next_vld,
    output t_rec      o_rec,
    output logic      o_vld,
    output logic      o_keep
);

    t_rec r_rec, n_rec;
    logic r_vld, n_vld;

    // a valid record stays in place when its key is not below the new one (ties keep order)
    assign o_keep = r_vld && !(r_rec.key < i_new.key);
    assign o_rec  = r_rec;
    assign o_vld  = r_vld;

    always_comb begin
        n_rec = r_rec;
        n_vld = r_vld;
        if (i_ctl.shl) begin
            n_rec = i_next_rec;
            n_vld = i_next_vld;
        end else if (i_ctl.ins && !o_keep) begin
            if (i_prev_keep) begin
                n_rec = i_new;
                n_vld = 1'b1;
            end else begin
                n_rec = i_prev_rec;
                n_vld = i_prev_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

### rtl/record_sort_descending.sv
// ----------------------------------------------------------------------------
// record_sort_descending: stable descending-key record sorter
// Load: one record per cycle into a chain of CAPACITY cells, all compared
// in parallel with the new key. Records past CAPACITY are dropped and flagged.
// Drain: after the last_in beat, N result beats leave cell 0, one per cycle
// while i_ready is high; the next batch loads the cycle after the final beat.
// Reset (synchronous, active low) empties the chain and clears the flags.
// ----------------------------------------------------------------------------
module record_sort_descending
    import rsd_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    t_rec      w_new;
    t_rec      w_rec      [CAPACITY];
    logic      w_vld      [CAPACITY];
    logic      w_keep     [CAPACITY];
    t_rec      w_prev_rec [CAPACITY];
    logic      w_prev_vld [CAPACITY];
    logic      w_prev_keep[CAPACITY];
    t_rec      w_next_rec [CAPACITY];
    logic      w_next_vld [CAPACITY];
    t_cell_ctl w_ctl;
    logic      w_in_acc, w_out_acc, w_full, w_last;
    logic      r_drain, r_ovf;

    assign w_new.key        = i_data.key_value;
    assign w_new.x          = i_data.x_coord;
    assign w_new.y          = i_data.y_coord;
    assign w_new.z          = i_data.z_coord;
    assign w_new.dest_value = i_data.dest_value;
    assign w_new.dest_x     = i_data.dest_x;
    assign w_new.dest_y     = i_data.dest_y;
    assign w_new.dest_z     = i_data.dest_z;

    assign o_ready   = !r_drain;
    assign o_valid   = r_drain;
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;
    assign w_full    = w_vld[CAPACITY-1];
    assign w_last    = w_vld[0] && !w_vld[1];

    assign w_ctl.ins = w_in_acc && !w_full;
    assign w_ctl.shl = w_out_acc;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev_rec[g]  = w_new;
            assign w_prev_vld[g]  = 1'b1;
            assign w_prev_keep[g] = 1'b1;
        end else begin : g_body
            assign w_prev_rec[g]  = w_rec[g-1];
            assign w_prev_vld[g]  = w_vld[g-1];
            assign w_prev_keep[g] = w_keep[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_rec[g] = w_new;
            assign w_next_vld[g] = 1'b0;
        end else begin : g_link
            assign w_next_rec[g] = w_rec[g+1];
            assign w_next_vld[g] = w_vld[g+1];
        end

        rsd_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_new      (w_new),
            .i_prev_rec (w_prev_rec[g]),
            .i_prev_vld (w_prev_vld[g]),
            .i_prev_keep(w_prev_keep[g]),
            .i_next_rec (w_next_rec[g]),
            .i_next_vld (w_next_vld[g]),
            .o_rec      (w_rec[g]),
            .o_vld      (w_vld[g]),
            .o_keep     (w_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            if (w_in_acc) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end
                if (i_data.last_in) begin
                    r_drain <= 1'b1;
                end
            end
            if (w_out_acc && w_last) begin
                r_drain <= 1'b0;
                r_ovf   <= 1'b0;
            end
        end
    end

    assign o_data.sorted_key        = w_rec[0].key;
    assign o_data.sorted_x          = w_rec[0].x;
    assign o_data.sorted_y          = w_rec[0].y;
    assign o_data.sorted_z          = w_rec[0].z;
    assign o_data.sorted_dest_value = w_rec[0].dest_value;
    assign o_data.sorted_dest_x     = w_rec[0].dest_x;
    assign o_data.sorted_dest_y     = w_rec[0].dest_y;
    assign o_data.sorted_dest_z     = w_rec[0].dest_z;
    assign o_data.last_out          = w_last;
    assign o_data.overflowed        = r_ovf;

endmodule

### rtl/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker: port-level checks for the descending record sorter
// Load and drain phases never overlap, and drain runs exactly to last_out.
// ----------------------------------------------------------------------------
module rsd_checker
    import rsd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_beat  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_beat o_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    // no load while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready during drain");

    // a batch end starts the drain
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.last_in |=> o_valid)
        else $error("no results after last_in");

    // drain continues until the beat marked last
    a_drain_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.last_out |=> o_valid)
        else $error("drain ended early");

    // drain stops after the beat marked last
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last_out |=> !o_valid)
        else $error("results past last_out");

endmodule

bind record_sort_descending rsd_checker u_rsd_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .i_data (i_data),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);
